// ===== design/vpa_pkg.sv =====
package vpa_pkg;

    localparam logic FUNC_NOTE_ON  = 1'b0;
    localparam logic FUNC_NOTE_OFF = 1'b1;

    localparam int AGE_W  = 32;
    localparam int NOTE_W = 7;

    typedef struct packed {
        logic              func;
        logic [NOTE_W-1:0] note_number;
        logic [6:0]        velocity;
    } t_in;

    typedef struct packed {
        logic [2:0]        voice_index;
        logic              voice_stolen;
        logic [7:0]        released_mask;
        logic [7:0]        active_mask;
        logic [NOTE_W-1:0] note_out;
        logic [6:0]        velocity_out;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic all_active;
        logic scan_last;
    } t_sts;

endpackage

// ===== design/vpa_ctrl.sv =====
module vpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  vpa_pkg::t_sts i_sts,
    output vpa_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    // free voice on note on: no scan needed
                    if (i_func == vpa_pkg::FUNC_NOTE_ON && !i_sts.all_active) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/vpa_datapath.sv =====
module vpa_datapath #(
    parameter int VOICES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vpa_pkg::t_in  i_in,
    input  vpa_pkg::t_cmd i_cmd,
    output vpa_pkg::t_sts o_sts,
    output vpa_pkg::t_out o_out,
    output logic          o_done
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0]             PTR_ONE = VW'(1);
    localparam logic [vpa_pkg::AGE_W-1:0] AGE_ONE = vpa_pkg::AGE_W'(1);

    logic [VOICES-1:0]         r_active;
    logic [vpa_pkg::NOTE_W-1:0] r_note [VOICES];
    logic [vpa_pkg::AGE_W-1:0]  r_age  [VOICES];
    logic [vpa_pkg::AGE_W-1:0]  r_counter;

    vpa_pkg::t_in      r_item;
    logic              r_steal;
    logic [VW-1:0]     r_ptr;
    logic [VW-1:0]     r_best_idx;
    logic [vpa_pkg::AGE_W-1:0] r_best_age;
    logic [VOICES-1:0] r_released;
    vpa_pkg::t_out     r_out;
    logic              r_done;

    logic [VW-1:0]     w_free;
    logic [VW-1:0]     w_pick;
    logic [VOICES-1:0] w_pick_oh;
    logic              w_is_on;
    logic              w_hit;
    logic [VOICES-1:0] w_act_after;
    logic [31:0]       w_act_ext;
    logic [31:0]       w_rel_ext;
    logic [31:0]       w_idx_ext;

    // lowest inactive voice
    always_comb begin
        w_free = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free = VW'(i);
            end
        end
    end

    assign w_is_on   = (r_item.func == vpa_pkg::FUNC_NOTE_ON);
    assign w_pick    = r_steal ? r_best_idx : w_free;
    assign w_hit     = r_active[r_ptr] && (r_note[r_ptr] == r_item.note_number);

    always_comb begin
        w_pick_oh         = '0;
        w_pick_oh[w_pick] = 1'b1;
    end

    assign w_act_after = w_is_on ? (r_active | w_pick_oh) : r_active;
    assign w_act_ext   = 32'(w_act_after);
    assign w_rel_ext   = 32'(r_released);
    assign w_idx_ext   = 32'(w_pick);

    assign o_sts.all_active = &r_active;
    assign o_sts.scan_last  = (r_ptr == VW'(VOICES - 1));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_counter <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.scan && !w_is_on && w_hit) begin
                r_active[r_ptr] <= 1'b0;
            end
            if (i_cmd.commit && w_is_on) begin
                r_active[w_pick] <= 1'b1;
                r_counter        <= r_counter + AGE_ONE;
            end
        end
    end

    // voice store and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item     <= i_in;
            r_steal    <= &r_active;
            r_ptr      <= '0;
            r_released <= '0;
        end
        if (i_cmd.scan) begin
            r_ptr <= r_ptr + PTR_ONE;
            if (w_is_on) begin
                if (r_ptr == '0 || r_age[r_ptr] < r_best_age) begin
                    r_best_age <= r_age[r_ptr];
                    r_best_idx <= r_ptr;
                end
            end else if (w_hit) begin
                r_released[r_ptr] <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            if (w_is_on) begin
                r_note[w_pick] <= r_item.note_number;
                r_age[w_pick]  <= r_counter;
            end
            r_out.voice_index   <= w_is_on ? w_idx_ext[2:0] : 3'd0;
            r_out.voice_stolen  <= w_is_on && r_steal;
            r_out.released_mask <= w_is_on ? 8'd0 : w_rel_ext[7:0];
            r_out.active_mask   <= w_act_ext[7:0];
            r_out.note_out      <= r_item.note_number;
            r_out.velocity_out  <= w_is_on ? r_item.velocity : 7'd0;
        end
    end

    assign o_out  = r_out;
    assign o_done = r_done;

endmodule

// ===== design/poly_voice_allocator_unit.sv =====
// A note on that finds a free voice goes from start straight to commit; a note on that steals
// and every note off first scan all voices, one voice read per cycle, then commit.
// The result beat is registered from the commit state; start is taken again in the
// cycle that carries the result strobe. The receiver cannot stall: o_done lasts one cycle.
// Reset (synchronous, i_rst_n low): all voices inactive, age counter zero, no strobe.
module poly_voice_allocator_unit #(
    parameter int VOICES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vpa_pkg::t_in  i_in,
    output logic          o_done,
    output vpa_pkg::t_out o_out
);

    // controller <-> datapath
    vpa_pkg::t_cmd w_cmd;
    vpa_pkg::t_sts w_sts;
    logic          w_busy;

    // Controller: idle -> (scan) -> commit -> idle. The scan walks the voices
    // either to find the oldest age stamp (steal) or to release matching notes.
    vpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_in.func),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    // Datapath: per-voice flags, notes and age stamps, the age counter,
    // the scan pointer and the registered result beat.
    vpa_datapath #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out),
        .o_done  (o_done)
    );

    assign busy = w_busy;

endmodule

// ===== design/vpa_checker.sv =====
module vpa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input vpa_pkg::t_in  i_in,
    input logic          o_done,
    input vpa_pkg::t_out o_out
);

    // accepted beat makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    // result strobe comes exactly when work finishes
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("no result beat when busy fell");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // released voices are no longer active
    a_release_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_out.released_mask & o_out.active_mask) == 8'd0))
        else $error("released voice still active");

    // a note off reports no voice assignment
    a_off_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.released_mask != 8'd0) |->
            (o_out.voice_index == 3'd0 && !o_out.voice_stolen && o_out.velocity_out == 7'd0))
        else $error("note off beat carries assignment fields");

endmodule

bind poly_voice_allocator_unit vpa_checker u_vpa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_in    (i_in),
    .o_done  (o_done),
    .o_out   (o_out)
);
